>>> hdl/pfss_pkg.sv
// Shared types, constants and rotation table of the segment subdivider.
`default_nettype none
package pfss_pkg;

  localparam int COORD_W = 32;
  localparam int STEP_W = 4;
  localparam int COEF_W = 32;
  localparam int COEF_SHIFT = 30;
  localparam int VEC_W = 34;
  localparam int PNT_W = 40;
  localparam int PFSS_MAX_SIDES = 8;
  localparam int PFSS_MAX_POLYS = 7;
  localparam int PFSS_DIV_NUM_W = 42;
  localparam int PFSS_DIV_DEN_W = 9;

  typedef enum logic [2:0] {
    CFG_SIDES          = 3'd0,
    CFG_SIDES_ALT      = 3'd1,
    CFG_POLY_COUNT     = 3'd2,
    CFG_POLY_COUNT_ALT = 3'd3,
    CFG_DIVISIONS      = 3'd4,
    CFG_DIVISIONS_ALT  = 3'd5,
    CFG_MODE_FLAGS     = 3'd6,
    CFG_UNUSED         = 3'd7
  } cfg_idx_t;

  // cos and sin of (n-2)*pi/n, Q2.30
  function automatic logic signed [COEF_W-1:0] coef_cos(input logic [3:0] n);
    logic signed [COEF_W-1:0] c;
    case (n)
      4'd4:    c = 32'sd0;
      4'd5:    c = -32'sd331804471;
      4'd6:    c = -32'sd536870912;
      4'd7:    c = -32'sd669467077;
      4'd8:    c = -32'sd759250125;
      default: c = 32'sd536870912;
    endcase
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_sin(input logic [3:0] n);
    logic signed [COEF_W-1:0] s;
    case (n)
      4'd4:    s = 32'sd1073741824;
      4'd5:    s = 32'sd1021189159;
      4'd6:    s = 32'sd929887697;
      4'd7:    s = 32'sd839485162;
      4'd8:    s = 32'sd759250125;
      default: s = 32'sd929887697;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> hdl/pfss_if.sv
// Request channel interfaces: input segment and child segment.
`default_nettype none
interface pfss_seg_if import pfss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic [STEP_W-1:0]         generation;
  logic [STEP_W-1:0]         target_step;
  logic [STEP_W-1:0]         parent_step;

  modport source (output valid, start_x, start_y, end_x, end_y, generation,
                  target_step, parent_step, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, generation,
                target_step, parent_step, output ready);
endinterface

interface pfss_child_if import pfss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] child_start_x;
  logic signed [COORD_W-1:0] child_start_y;
  logic signed [COORD_W-1:0] child_end_x;
  logic signed [COORD_W-1:0] child_end_y;
  logic [STEP_W-1:0]         child_parent_step;
  logic [STEP_W-1:0]         child_generation;
  logic                      last;

  modport source (output valid, child_start_x, child_start_y, child_end_x,
                  child_end_y, child_parent_step, child_generation, last,
                  input ready);
  modport sink (input valid, child_start_x, child_start_y, child_end_x,
                child_end_y, child_parent_step, child_generation, last,
                output ready);
endinterface
`default_nettype wire

>>> hdl/pfss_div.sv
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module pfss_div import pfss_pkg::*; #(
  parameter int NUM_W = PFSS_DIV_NUM_W,
  parameter int DEN_W = PFSS_DIV_DEN_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   sh;
  logic             fits;

  assign sh   = {rem_r, quo_r[NUM_W-1]};
  assign fits = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? DEN_W'(sh - {1'b0, den_r}) : sh[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule
`default_nettype wire

>>> hdl/polygon_fractal_segment_subdivider.sv
// Top level: Koch-style segment subdivider with a shared multiplier and divider.
//
// Each accepted segment whose target step differs from its generation yields
// 1 + polys*sides child segments, the final one flagged with last; a segment
// whose target step equals its generation yields nothing and the block stays
// ready. Work is sequential, one segment at a time: setup runs two rounded
// divisions (four with fixed division, the last two each preceded by one
// multiply) on the 42-bit bit-serial divider, then every polygon edge is
// rotated in the S_ROT phases on the single 34x32 multiplier and issued from
// S_EDGE, and every side piece is issued from S_SIDE; both wait while the
// child channel stalls. Coordinates are signed Q16.16, saturated on output.
`default_nettype none
module polygon_fractal_segment_subdivider import pfss_pkg::*; #(
  parameter int MAX_SIDES = PFSS_MAX_SIDES,
  parameter int MAX_POLYS = PFSS_MAX_POLYS,
  parameter int DIV_NUM_W = PFSS_DIV_NUM_W,
  parameter int DIV_DEN_W = PFSS_DIV_DEN_W
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_we,
  input  wire cfg_idx_t cfg_idx,
  input  wire logic [5:0] cfg_wdata,
  pfss_seg_if.sink      in_seg,
  pfss_child_if.source  out_child
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DMUL  = 7'b0000010,
    S_DPREP = 7'b0000100,
    S_DRUN  = 7'b0001000,
    S_SIDE  = 7'b0010000,
    S_ROT   = 7'b0100000,
    S_EDGE  = 7'b1000000
  } state_t;

  localparam int PROD_W = VEC_W + COEF_W;
  localparam int ACC_W  = PROD_W + 1;

  // configuration
  logic [3:0] sides_r, sides_alt_r;
  logic [2:0] poly_count_r, poly_count_alt_r;
  logic [5:0] divisions_r, divisions_alt_r;
  logic [3:0] mode_flags_r;
  logic [2:0] p_chk;

  always_comb begin
    p_chk = mode_flags_r[1] ? poly_count_alt_r : poly_count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sides_r          <= 4'd3;
      sides_alt_r      <= 4'd3;
      poly_count_r     <= 3'd1;
      poly_count_alt_r <= 3'd1;
      divisions_r      <= 6'd3;
      divisions_alt_r  <= 6'd3;
      mode_flags_r     <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SIDES: begin
          if (cfg_wdata[3:0] >= 4'd3 && cfg_wdata[3:0] <= 4'(MAX_SIDES))
            sides_r <= cfg_wdata[3:0];
        end
        CFG_SIDES_ALT: begin
          if (cfg_wdata[3:0] >= 4'd3 && cfg_wdata[3:0] <= 4'(MAX_SIDES))
            sides_alt_r <= cfg_wdata[3:0];
        end
        CFG_POLY_COUNT: begin
          if (cfg_wdata[2:0] >= 3'd1 && cfg_wdata[2:0] <= 3'(MAX_POLYS))
            poly_count_r <= cfg_wdata[2:0];
        end
        CFG_POLY_COUNT_ALT: begin
          if (cfg_wdata[2:0] >= 3'd1 && cfg_wdata[2:0] <= 3'(MAX_POLYS))
            poly_count_alt_r <= cfg_wdata[2:0];
        end
        CFG_DIVISIONS: begin
          if (cfg_wdata[0] && cfg_wdata >= {2'b00, poly_count_r, 1'b1})
            divisions_r <= cfg_wdata;
        end
        CFG_DIVISIONS_ALT: begin
          if (cfg_wdata[0] && cfg_wdata >= {2'b00, p_chk, 1'b1})
            divisions_alt_r <= cfg_wdata;
        end
        CFG_MODE_FLAGS: mode_flags_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_t state_r;
  logic [1:0] dsel_r;
  logic [2:0] phase_r;
  logic [2:0] poly_idx_r;
  logic [2:0] edge_idx_r;
  logic       first_r;

  // per-segment registers
  logic [3:0]              n_r;
  logic [2:0]              polys_r;
  logic [5:0]              div_r;
  logic                    fixed_r;
  logic signed [7:0]       num_r;
  logic [8:0]              den_r;
  logic [STEP_W-1:0]       ngen_r;
  logic [STEP_W-1:0]       par_r;
  logic signed [32:0]      dx_r, dy_r;
  logic signed [VEC_W-1:0] vpx_r, vpy_r, vcx_r, vcy_r, vx_r, vy_r;
  logic signed [PNT_W-1:0] px_r, py_r;

  // shared arithmetic
  logic signed [VEC_W-1:0]  ma;
  logic signed [COEF_W-1:0] mb;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  rnd_t;
  logic signed [VEC_W-1:0]  rnd_q;
  logic signed [VEC_W-1:0]  rnd_v;
  logic signed [COEF_W-1:0] cc, ss;

  // divider link
  logic                        div_start_r;
  logic [DIV_NUM_W-1:0]        div_num_r;
  logic [DIV_DEN_W-1:0]        div_den_r;
  logic                        div_neg_r;
  logic                        div_done;
  logic [DIV_NUM_W-1:0]        div_quot;
  logic signed [DIV_NUM_W-1:0] dsrc;
  logic [DIV_NUM_W-1:0]        dmag;
  logic [DIV_DEN_W-1:0]        dden;
  logic signed [VEC_W-1:0]     dres;

  // output register
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] o_sx_r, o_sy_r, o_ex_r, o_ey_r;
  logic [STEP_W-1:0]         o_ps_r, o_gen_r;
  logic                      o_last_r;
  logic                      out_free;
  logic                      emit;
  logic                      side_last;
  logic                      edges_done;

  // segment setup from the request
  logic              alt;
  logic [5:0]        div_sel;
  logic [2:0]        polys_sel;
  logic [3:0]        n_sel;

  // emitted piece
  logic signed [VEC_W-1:0] ex_v, ey_v;
  logic signed [PNT_W-1:0] qx, qy;

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [PNT_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v[PNT_W-1:COORD_W-1] == '0 || v[PNT_W-1:COORD_W-1] == '1) r = v[COORD_W-1:0];
    else if (v[PNT_W-1]) r = {1'b1, {(COORD_W-1){1'b0}}};
    else r = {1'b0, {(COORD_W-1){1'b1}}};
    return r;
  endfunction

  assign alt       = in_seg.generation[0];
  assign div_sel   = (alt && (mode_flags_r[1] || (mode_flags_r[2] && mode_flags_r[3])))
                     ? divisions_alt_r : divisions_r;
  assign polys_sel = (alt && mode_flags_r[1]) ? poly_count_alt_r : poly_count_r;
  assign n_sel     = (alt && mode_flags_r[0]) ? sides_alt_r : sides_r;

  assign cc = coef_cos(n_r);
  assign ss = coef_sin(n_r);

  always_comb begin
    ma = vx_r;
    mb = cc;
    if (state_r == S_DMUL) begin
      ma = dsel_r[0] ? VEC_W'(dy_r) : VEC_W'(dx_r);
      mb = COEF_W'(num_r);
    end else begin
      case (phase_r)
        3'd1:    begin ma = vy_r; mb = ss; end
        3'd2:    begin ma = vy_r; mb = cc; end
        3'd3:    begin ma = vx_r; mb = ss; end
        default: begin ma = vx_r; mb = cc; end
      endcase
    end
  end

  always_comb begin
    rnd_t = acc_r + (acc_r[ACC_W-1] ? ACC_W'(64'sd536870911) : ACC_W'(64'sd536870912));
    rnd_q = VEC_W'(rnd_t >>> COEF_SHIFT);
    rnd_v = first_r ? rnd_q : -rnd_q;
  end

  always_comb begin
    case (dsel_r)
      2'd0:    dsrc = DIV_NUM_W'(dx_r);
      2'd1:    dsrc = DIV_NUM_W'(dy_r);
      default: dsrc = prod_r[DIV_NUM_W-1:0];
    endcase
    dmag = dsrc[DIV_NUM_W-1] ? DIV_NUM_W'(-dsrc) : DIV_NUM_W'(dsrc);
    dden = dsel_r[1] ? DIV_DEN_W'(den_r) : DIV_DEN_W'(div_r);
    dres = div_neg_r ? -VEC_W'(div_quot) : VEC_W'(div_quot);
  end

  assign out_free   = !out_valid_r || out_child.ready;
  assign side_last  = poly_idx_r == polys_r;
  assign edges_done = ({1'b0, edge_idx_r} + 4'd1) == (n_r - 4'd1);
  assign emit       = out_free && (state_r == S_SIDE || state_r == S_EDGE);
  assign ex_v       = (state_r == S_SIDE) ? vcx_r : vx_r;
  assign ey_v       = (state_r == S_SIDE) ? vcy_r : vy_r;
  assign qx         = px_r + PNT_W'(ex_v);
  assign qy         = py_r + PNT_W'(ey_v);

  pfss_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dsel_r      <= 2'd0;
      phase_r     <= 3'd0;
      poly_idx_r  <= 3'd0;
      edge_idx_r  <= 3'd0;
      first_r     <= 1'b1;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (emit) out_valid_r <= 1'b1;
      else if (out_child.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_seg.valid && in_seg.target_step != in_seg.generation) begin
            dsel_r     <= 2'd0;
            poly_idx_r <= 3'd0;
            edge_idx_r <= 3'd0;
            state_r    <= S_DPREP;
          end
        end
        S_DMUL:  state_r <= S_DPREP;
        S_DPREP: begin
          div_start_r <= 1'b1;
          state_r     <= S_DRUN;
        end
        S_DRUN: begin
          if (div_done) begin
            dsel_r <= dsel_r + 2'd1;
            case (dsel_r)
              2'd0:    state_r <= S_DPREP;
              2'd1:    state_r <= fixed_r ? S_DMUL : S_SIDE;
              2'd2:    state_r <= S_DMUL;
              default: state_r <= S_SIDE;
            endcase
          end
        end
        S_SIDE: begin
          if (out_free) begin
            if (side_last) begin
              state_r <= S_IDLE;
            end else begin
              first_r <= 1'b1;
              phase_r <= 3'd0;
              state_r <= S_ROT;
            end
          end
        end
        S_ROT: begin
          if (phase_r == 3'd5) begin
            phase_r <= 3'd0;
            state_r <= S_EDGE;
          end else begin
            phase_r <= phase_r + 3'd1;
          end
        end
        S_EDGE: begin
          if (out_free) begin
            first_r <= 1'b0;
            if (edges_done) begin
              edge_idx_r <= 3'd0;
              poly_idx_r <= poly_idx_r + 3'd1;
              state_r    <= S_SIDE;
            end else begin
              edge_idx_r <= edge_idx_r + 3'd1;
              phase_r    <= 3'd0;
              state_r    <= S_ROT;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    case (state_r)
      S_IDLE: begin
        if (in_seg.valid) begin
          n_r     <= n_sel;
          polys_r <= polys_sel;
          div_r   <= div_sel;
          fixed_r <= mode_flags_r[2];
          num_r   <= $signed({2'b00, div_sel}) - $signed({5'b00000, polys_sel});
          den_r   <= 9'(div_sel) * (9'(polys_sel) + 9'd1);
          ngen_r  <= (in_seg.generation == '1) ? in_seg.generation
                     : in_seg.generation + 1'b1;
          par_r   <= in_seg.parent_step;
          dx_r    <= 33'(in_seg.end_x) - 33'(in_seg.start_x);
          dy_r    <= 33'(in_seg.end_y) - 33'(in_seg.start_y);
          px_r    <= PNT_W'(in_seg.start_x);
          py_r    <= PNT_W'(in_seg.start_y);
        end
      end
      S_DPREP: begin
        div_num_r <= dmag + DIV_NUM_W'(dden >> 1);
        div_den_r <= dden;
        div_neg_r <= dsrc[DIV_NUM_W-1];
      end
      S_DRUN: begin
        if (div_done) begin
          case (dsel_r)
            2'd0: vpx_r <= dres;
            2'd1: begin
              vpy_r <= dres;
              if (!fixed_r) begin
                vcx_r <= vpx_r;
                vcy_r <= dres;
              end
            end
            2'd2:    vcx_r <= dres;
            default: vcy_r <= dres;
          endcase
        end
      end
      S_SIDE: begin
        if (out_free) begin
          px_r <= qx;
          py_r <= qy;
          vx_r <= vpx_r;
          vy_r <= vpy_r;
        end
      end
      S_ROT: begin
        case (phase_r)
          3'd1: acc_r <= {prod_r[PROD_W-1], prod_r};
          3'd2: acc_r <= acc_r + {prod_r[PROD_W-1], prod_r};
          3'd3: begin
            vx_r  <= rnd_v;
            acc_r <= {prod_r[PROD_W-1], prod_r};
          end
          3'd4: acc_r <= acc_r - {prod_r[PROD_W-1], prod_r};
          3'd5: vy_r  <= rnd_v;
          default: ;
        endcase
      end
      S_EDGE: begin
        if (out_free) begin
          px_r <= qx;
          py_r <= qy;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_sx_r   <= sat(px_r);
      o_sy_r   <= sat(py_r);
      o_ex_r   <= sat(qx);
      o_ey_r   <= sat(qy);
      o_ps_r   <= (state_r == S_SIDE) ? par_r : ngen_r;
      o_gen_r  <= ngen_r;
      o_last_r <= (state_r == S_SIDE) && side_last;
    end
  end

  assign in_seg.ready                = state_r == S_IDLE;
  assign out_child.valid             = out_valid_r;
  assign out_child.child_start_x     = o_sx_r;
  assign out_child.child_start_y     = o_sy_r;
  assign out_child.child_end_x       = o_ex_r;
  assign out_child.child_end_y       = o_ey_r;
  assign out_child.child_parent_step = o_ps_r;
  assign out_child.child_generation  = o_gen_r;
  assign out_child.last              = o_last_r;

`ifndef SYNTH
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DRUN)
    else $error("divider finished outside its wait state");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && state_r == S_SIDE && side_last) |=> state_r == S_IDLE)
    else $error("sequencer busy after final child");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= 3'd5)
    else $error("rotation phase out of range");

  a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EDGE |-> ({1'b0, edge_idx_r} + 4'd2) <= n_r)
    else $error("edge count beyond polygon sides");
`endif

endmodule
`default_nettype wire

>>> test/polygon_fractal_segment_subdivider_test.sv
// Testbench of the segment subdivider: directed, config sweep, random and back-pressure tests.
`default_nettype none
module polygon_fractal_segment_subdivider_test import pfss_pkg::*; ;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic signed [31:0] sx, sy, ex, ey;
    logic [3:0] gen, tgt, par;
  } seg_t;

  typedef struct {
    logic signed [31:0] sx, sy, ex, ey;
    logic [3:0] pstep, gen;
    logic last;
  } child_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_idx = CFG_SIDES;
  logic [5:0] cfg_wdata = '0;
  logic hold_off = 1'b0;
  logic stall_on = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_cnt = 0;
  int err_cnt = 0;
  int seg_cnt = 0;
  int child_cnt = 0;

  // register copies
  int unsigned r_sides = 3, r_sides_alt = 3, r_polys = 1, r_polys_alt = 1;
  int unsigned r_div = 3, r_div_alt = 3, r_mode = 0;

  child_t child_q[$];

  longint cos_q30[6] = '{536870912, 0, -331804471, -536870912, -669467077, -759250125};
  longint sin_q30[6] = '{929887697, 1073741824, 1021189159, 929887697, 839485162,
                         759250125};

  pfss_seg_if   seg_ch();
  pfss_child_if child_ch();

  polygon_fractal_segment_subdivider dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_seg(seg_ch.sink), .out_child(child_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    seg_ch.valid = 1'b0;
    seg_ch.start_x = '0;
    seg_ch.start_y = '0;
    seg_ch.end_x = '0;
    seg_ch.end_y = '0;
    seg_ch.generation = '0;
    seg_ch.target_step = '0;
    seg_ch.parent_step = '0;
    child_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: alternate between free flow and random stalls
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_cnt <= $urandom_range(50, 400);
      stall_on <= ($urandom_range(0, 2) != 0);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    child_ch.ready <= rst_n && !hold_off && (!stall_on || $urandom_range(0, 3) != 0);
  end

  function automatic longint round_div(longint num, longint den);
    longint m, q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void push_child(longint fx, longint fy, longint tx, longint ty,
                                     logic [3:0] pstep, logic [3:0] gen);
    child_t c;
    c.sx = sat32(fx);
    c.sy = sat32(fy);
    c.ex = sat32(tx);
    c.ey = sat32(ty);
    c.pstep = pstep;
    c.gen = gen;
    c.last = 1'b0;
    child_q = {child_q, c};
  endfunction

  function automatic void predict_children(seg_t s);
    int unsigned n, polys, dv;
    logic [3:0] ngen;
    longint dx, dy, vpx, vpy, vcx, vcy, px, py, vx, vy, c, sn, t, one;
    if (s.tgt == s.gen) return;
    one = longint'(1) <<< 30;
    ngen = (s.gen < 4'd15) ? s.gen + 4'd1 : 4'd15;
    n = r_sides;
    polys = r_polys;
    dv = r_div;
    if (s.gen[0]) begin
      if (r_mode[1] || (r_mode[2] && r_mode[3])) dv = r_div_alt;
      if (r_mode[1]) polys = r_polys_alt;
      if (r_mode[0]) n = r_sides_alt;
    end
    dx = longint'(s.ex) - longint'(s.sx);
    dy = longint'(s.ey) - longint'(s.sy);
    vpx = round_div(dx, dv);
    vpy = round_div(dy, dv);
    if (r_mode[2]) begin
      vcx = round_div(dx * (longint'(dv) - polys), longint'(dv) * (polys + 1));
      vcy = round_div(dy * (longint'(dv) - polys), longint'(dv) * (polys + 1));
    end else begin
      vcx = vpx;
      vcy = vpy;
    end
    c = cos_q30[n - 3];
    sn = sin_q30[n - 3];
    px = s.sx;
    py = s.sy;
    push_child(px, py, px + vcx, py + vcy, s.par, ngen);
    px += vcx;
    py += vcy;
    for (int j = 0; j < polys; j++) begin
      vx = round_div(vpx * c + vpy * sn, one);
      vy = round_div(vpy * c - vpx * sn, one);
      push_child(px, py, px + vx, py + vy, ngen, ngen);
      px += vx;
      py += vy;
      for (int k = 0; k + 2 < n; k++) begin
        t = -round_div(vx * c + vy * sn, one);
        vy = -round_div(vy * c - vx * sn, one);
        vx = t;
        push_child(px, py, px + vx, py + vy, ngen, ngen);
        px += vx;
        py += vy;
      end
      push_child(px, py, px + vcx, py + vcy, s.par, ngen);
      px += vcx;
      py += vcy;
    end
    child_q[child_q.size() - 1].last = 1'b1;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (child %0d)", what, got, want, child_cnt);
    err_cnt++;
  endtask

  // check each accepted child against the oldest prediction
  always @(posedge clk) begin
    child_t w;
    if (rst_n && child_ch.valid && child_ch.ready) begin
      if (child_q.size() == 0) begin
        report("unexpected child", 0, 0);
      end else begin
        w = child_q.pop_front();
        if (child_ch.child_start_x !== w.sx) report("start_x", child_ch.child_start_x, w.sx);
        if (child_ch.child_start_y !== w.sy) report("start_y", child_ch.child_start_y, w.sy);
        if (child_ch.child_end_x !== w.ex) report("end_x", child_ch.child_end_x, w.ex);
        if (child_ch.child_end_y !== w.ey) report("end_y", child_ch.child_end_y, w.ey);
        if (child_ch.child_parent_step !== w.pstep)
          report("parent_step", child_ch.child_parent_step, w.pstep);
        if (child_ch.child_generation !== w.gen)
          report("generation", child_ch.child_generation, w.gen);
        if (child_ch.last !== w.last) report("last", child_ch.last, w.last);
      end
      child_cnt++;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [5:0] data);
    int unsigned v, p;
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_SIDES: begin
        v = data & 15;
        if (v >= 3 && v <= 8) r_sides = v;
      end
      CFG_SIDES_ALT: begin
        v = data & 15;
        if (v >= 3 && v <= 8) r_sides_alt = v;
      end
      CFG_POLY_COUNT: begin
        v = data & 7;
        if (v >= 1) r_polys = v;
      end
      CFG_POLY_COUNT_ALT: begin
        v = data & 7;
        if (v >= 1) r_polys_alt = v;
      end
      CFG_DIVISIONS: begin
        v = data;
        if (v[0] && v >= 1 + 2 * r_polys) r_div = v;
      end
      CFG_DIVISIONS_ALT: begin
        v = data;
        p = r_mode[1] ? r_polys_alt : r_polys;
        if (v[0] && v >= 1 + 2 * p) r_div_alt = v;
      end
      CFG_MODE_FLAGS: r_mode = data & 15;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid, then wait for every predicted child
  task automatic drain();
    seg_ch.valid <= 1'b0;
    while (child_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves valid high; the caller lowers it for a gap
  task automatic send_seg(seg_t s);
    seg_ch.valid <= 1'b1;
    seg_ch.start_x <= s.sx;
    seg_ch.start_y <= s.sy;
    seg_ch.end_x <= s.ex;
    seg_ch.end_y <= s.ey;
    seg_ch.generation <= s.gen;
    seg_ch.target_step <= s.tgt;
    seg_ch.parent_step <= s.par;
    do @(posedge clk); while (!seg_ch.ready);
    predict_children(s);
    seg_cnt++;
  endtask

  task automatic idle(int unsigned cycles);
    if (cycles == 0) return;
    seg_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic seg_t make_seg(logic signed [31:0] sx, logic signed [31:0] sy,
                                    logic signed [31:0] ex, logic signed [31:0] ey,
                                    logic [3:0] gen, logic [3:0] tgt, logic [3:0] par);
    seg_t s;
    s.sx = sx; s.sy = sy; s.ex = ex; s.ey = ey;
    s.gen = gen; s.tgt = tgt; s.par = par;
    return s;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7fffffff - $urandom_range(0, 255);
      2: return 32'sh80000000 + $urandom_range(0, 255);
      default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
    endcase
  endfunction

  function automatic seg_t rand_seg();
    seg_t s;
    s.sx = rand_coord();
    s.sy = rand_coord();
    s.ex = rand_coord();
    s.ey = rand_coord();
    s.gen = 4'($urandom());
    s.tgt = ($urandom_range(0, 6) == 0) ? s.gen : 4'($urandom());
    s.par = 4'($urandom());
    return s;
  endfunction

  task automatic test_directed();
    send_seg(make_seg(0, 0, 32'sh00030000, 0, 0, 1, 0));
    send_seg(make_seg(0, 0, 32'sh00030000, 0, 2, 2, 5));
    send_seg(make_seg(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1, 3, 15));
    send_seg(make_seg(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 14, 2, 9));
    send_seg(make_seg(100, 200, 100, 200, 15, 0, 7));
    send_seg(make_seg(-5, 7, 11, -13, 15, 15, 3));
    send_seg(make_seg(32'sh00010000, 32'sh00020000, -32'sh00050000, 32'sh00040000, 8, 3, 2));
    idle(2);
    send_seg(make_seg(1, -1, -1, 1, 7, 6, 10));
    drain();
    write_reg(CFG_SIDES, 8);
    write_reg(CFG_POLY_COUNT, 7);
    write_reg(CFG_DIVISIONS, 63);
    write_reg(CFG_MODE_FLAGS, 4);
    send_seg(make_seg(32'sh80000000, 0, 32'sh7fffffff, 32'sh00100000, 0, 1, 4));
    send_seg(make_seg(-32'sh00640000, 32'sh00320000, 32'sh00640000, -32'sh00320000, 3, 1, 6));
    drain();
    // fixed division with div below polys: reversed side pieces
    write_reg(CFG_POLY_COUNT, 1);
    write_reg(CFG_DIVISIONS, 3);
    write_reg(CFG_POLY_COUNT, 7);
    write_reg(CFG_SIDES, 3);
    send_seg(make_seg(0, 0, 32'sh00150000, 32'sh00070000, 2, 9, 1));
    drain();
    write_reg(CFG_DIVISIONS, 9);
    send_seg(make_seg(0, 0, 32'sh00150000, 32'sh00070000, 2, 9, 1));
    drain();
  endtask

  task automatic test_config_sweep();
    logic [5:0] bad[8] = '{0, 2, 9, 15, 7, 8, 4, 1};
    for (int m = 0; m < 16; m++) begin
      write_reg(CFG_MODE_FLAGS, 6'(m));
      write_reg(CFG_SIDES, 6'(3 + (m % 6)));
      write_reg(CFG_SIDES_ALT, 6'(8 - (m % 6)));
      write_reg(CFG_POLY_COUNT, 6'(1 + (m % 3)));
      write_reg(CFG_POLY_COUNT_ALT, 6'(3 - (m % 3)));
      write_reg(CFG_DIVISIONS, 6'((m % 2) ? 63 : 7));
      write_reg(CFG_DIVISIONS_ALT, 6'((m % 3) ? 9 : 63));
      write_reg(CFG_UNUSED, 6'($urandom()));
      write_reg(cfg_idx_t'(m % 6), bad[m % 8]);
      send_seg(make_seg(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1, 0, 4'(m)));
      send_seg(make_seg(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 2, 0, 4'(m)));
      idle($urandom_range(0, 3));
      drain();
    end
  endtask

  task automatic test_random(int items);
    int sent;
    int burst;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 3) == 0) begin
        idle(0);
        drain();
        for (int r = 0; r < 3; r++)
          write_reg(cfg_idx_t'($urandom_range(0, 7)), 6'($urandom()));
        if ($urandom_range(0, 3) == 0) begin
          write_reg(CFG_SIDES, 8);
          write_reg(CFG_POLY_COUNT, 7);
          write_reg(CFG_DIVISIONS, 63);
        end
      end
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst; b++) begin
        send_seg(rand_seg());
        sent++;
      end
      idle($urandom_range(0, 6));
    end
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(CFG_SIDES, 4);
    write_reg(CFG_POLY_COUNT, 2);
    write_reg(CFG_DIVISIONS, 5);
    write_reg(CFG_MODE_FLAGS, 0);
    hold_off <= 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    for (int i = 0; i < 8; i++) send_seg(rand_seg());
    idle(0);
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random(110);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (child_q.size() != 0) report("children never delivered", 0, child_q.size());
    $display("covered %0d segments and %0d child segments over %0d cycles",
             seg_cnt, child_cnt, cycle_cnt);
    $display("register sweep, saturation, idle gaps and a long receiver hold included");
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
